[rtl/core/spq_pkg.sv]
// Shared types and constants of the sorted priority queue.
package spq_pkg;

  localparam int unsigned REQ_W   = 2;
  localparam int unsigned TAG_W   = 16;
  localparam int unsigned TIME_W  = 16;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned TOTAL_W = 28;
  localparam int unsigned AVG_W   = 30;
  localparam int unsigned FRAC_W  = 8;

  localparam logic [REQ_W-1:0] REQ_ENQ = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DEQ = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QRY = 2'd2;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [TAG_W-1:0]  job_tag;
    logic [TIME_W-1:0] job_time;
  } spq_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [TAG_W-1:0]   removed_tag;
    logic [TIME_W-1:0]  removed_time;
    logic [COUNT_W-1:0] entry_count;
    logic [TOTAL_W-1:0] total_completion;
    logic [AVG_W-1:0]   average_completion;
  } spq_rsp_t;

  typedef struct packed {
    logic [TAG_W-1:0]  job_tag;
    logic [TIME_W-1:0] job_time;
  } spq_entry_t;

endpackage

[rtl/core/spq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module spq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/sorted_priority_queue_avg_time.sv]
// Sorted priority queue (ascending time, equal times in arrival order) with
// completion-time statistics. One request is worked at a time through a single
// RAM port pair, each touched entry taking a read and then a compare/write:
// an enqueue shifts the entries behind the new job toward the rear, a dequeue
// moves every entry one place toward the head, and a query sums the completion
// times and then runs a bit-serial divide by the entry count. A full or empty
// case and an unknown request go straight to the response. The result sits in
// an output register, so the next request is taken while it waits.
module sorted_priority_queue_avg_time #(
  parameter int unsigned DEPTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  spq_pkg::spq_req_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output spq_pkg::spq_rsp_t out_data_o
);
  import spq_pkg::*;

  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned CW     = $clog2(DEPTH + 1);
  localparam int unsigned PREF_W = TIME_W + CW;
  localparam int unsigned SUM_W  = TIME_W + 2 * CW;
  localparam int unsigned DIV_W  = SUM_W + FRAC_W;
  localparam int unsigned DCW    = $clog2(DIV_W + 1);
  localparam int unsigned ENT_W  = $bits(spq_entry_t);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_ENQ_RD  = 10'b00_0000_0010,
    S_ENQ_CMP = 10'b00_0000_0100,
    S_DEQ_RD  = 10'b00_0000_1000,
    S_DEQ_WR  = 10'b00_0001_0000,
    S_QRY_RD  = 10'b00_0010_0000,
    S_QRY_ACC = 10'b00_0100_0000,
    S_QRY_FIN = 10'b00_1000_0000,
    S_DIV     = 10'b01_0000_0000,
    S_RESP    = 10'b10_0000_0000
  } state_e;

  state_e           state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic             out_valid_q, out_valid_d;
  spq_rsp_t         out_q, out_d;

  spq_req_t         req_q, req_d;
  logic [CW-1:0]    k_q, k_d;
  status_e          status_q, status_d;
  logic [TAG_W-1:0] rtag_q, rtag_d;
  logic [TIME_W-1:0] rtime_q, rtime_d;
  logic [PREF_W-1:0] prefix_q, prefix_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [DIV_W-1:0] quot_q, quot_d;
  logic [CW-1:0]    rem_q, rem_d;
  logic [DCW-1:0]   div_cnt_q, div_cnt_d;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  spq_entry_t       ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [ENT_W-1:0] ram_rdata;
  spq_entry_t       rd_entry;

  logic [CW-1:0]    k_inc;
  logic [CW-1:0]    k_dec;
  logic [CW:0]      trial;
  logic [SUM_W-1:0] sum_fin;
  logic             in_fire;
  spq_entry_t       new_entry;

  spq_ram #(
    .WIDTH(ENT_W),
    .DEPTH(DEPTH)
  ) u_spq_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_entry   = spq_entry_t'(ram_rdata);
  assign k_inc      = k_q + 1'b1;
  assign k_dec      = k_q - 1'b1;
  assign trial      = {rem_q, quot_q[DIV_W-1]};
  assign sum_fin    = sum_q + SUM_W'(prefix_q);
  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign new_entry  = '{job_tag: req_q.job_tag, job_time: req_q.job_time};

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    req_d       = req_q;
    k_d         = k_q;
    status_d    = status_q;
    rtag_d      = rtag_q;
    rtime_d     = rtime_q;
    prefix_d    = prefix_q;
    sum_d       = sum_q;
    quot_d      = quot_q;
    rem_d       = rem_q;
    div_cnt_d   = div_cnt_q;
    ram_we      = 1'b0;
    ram_waddr   = k_q[AW-1:0];
    ram_wdata   = rd_entry;
    ram_raddr   = k_q[AW-1:0];
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          req_d    = in_data_i;
          status_d = ST_OK;
          rtag_d   = '0;
          rtime_d  = '0;
          prefix_d = '0;
          sum_d    = '0;
          quot_d   = '0;
          case (in_data_i.req_type)
            REQ_ENQ: begin
              k_d = count_q;
              if (count_q == CW'(DEPTH)) begin
                status_d = ST_FULL;
                state_d  = S_RESP;
              end else begin
                state_d = S_ENQ_RD;
              end
            end
            REQ_DEQ: begin
              k_d = '0;
              if (count_q == '0) begin
                status_d = ST_EMPTY;
                state_d  = S_RESP;
              end else begin
                state_d = S_DEQ_RD;
              end
            end
            REQ_QRY: begin
              k_d = '0;
              if (count_q == '0) begin
                status_d = ST_EMPTY;
                state_d  = S_RESP;
              end else begin
                state_d = S_QRY_RD;
              end
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end

      S_ENQ_RD: begin
        if (k_q == '0) begin
          ram_we    = 1'b1;
          ram_wdata = new_entry;
          count_d   = count_q + 1'b1;
          state_d   = S_RESP;
        end else begin
          ram_raddr = k_dec[AW-1:0];
          state_d   = S_ENQ_CMP;
        end
      end

      S_ENQ_CMP: begin
        ram_we = 1'b1;
        if (rd_entry.job_time > req_q.job_time) begin
          // move the larger entry one place toward the rear
          ram_wdata = rd_entry;
          k_d       = k_dec;
          state_d   = S_ENQ_RD;
        end else begin
          ram_wdata = new_entry;
          count_d   = count_q + 1'b1;
          state_d   = S_RESP;
        end
      end

      S_DEQ_RD: begin
        state_d = S_DEQ_WR;
      end

      S_DEQ_WR: begin
        if (k_q == '0) begin
          rtag_d  = rd_entry.job_tag;
          rtime_d = rd_entry.job_time;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = k_dec[AW-1:0];
          ram_wdata = rd_entry;
        end
        k_d = k_inc;
        if (k_inc == count_q) begin
          count_d = count_q - 1'b1;
          state_d = S_RESP;
        end else begin
          state_d = S_DEQ_RD;
        end
      end

      S_QRY_RD: begin
        state_d = S_QRY_ACC;
      end

      S_QRY_ACC: begin
        // sum takes the previous prefix; the last prefix is added at the end
        prefix_d = prefix_q + PREF_W'(rd_entry.job_time);
        sum_d    = sum_q + SUM_W'(prefix_q);
        k_d      = k_inc;
        if (k_inc == count_q) begin
          state_d = S_QRY_FIN;
        end else begin
          state_d = S_QRY_RD;
        end
      end

      S_QRY_FIN: begin
        sum_d     = sum_fin;
        quot_d    = {sum_fin, {FRAC_W{1'b0}}};
        rem_d     = '0;
        div_cnt_d = DCW'(DIV_W);
        state_d   = S_DIV;
      end

      S_DIV: begin
        // restoring division, one quotient bit per cycle
        if (trial >= {1'b0, count_q}) begin
          rem_d  = CW'(trial - {1'b0, count_q});
          quot_d = {quot_q[DIV_W-2:0], 1'b1};
        end else begin
          rem_d  = trial[CW-1:0];
          quot_d = {quot_q[DIV_W-2:0], 1'b0};
        end
        div_cnt_d = div_cnt_q - 1'b1;
        if (div_cnt_q == DCW'(1)) begin
          state_d = S_RESP;
        end
      end

      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d                  = 1'b1;
          out_d.status                 = status_q;
          out_d.removed_tag            = rtag_q;
          out_d.removed_time           = rtime_q;
          out_d.entry_count            = COUNT_W'(count_q);
          out_d.total_completion       = TOTAL_W'(sum_q);
          out_d.average_completion     = AVG_W'(quot_q);
          state_d                      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q     <= out_d;
    req_q     <= req_d;
    k_q       <= k_d;
    status_q  <= status_d;
    rtag_q    <= rtag_d;
    rtime_q   <= rtime_d;
    prefix_q  <= prefix_d;
    sum_q     <= sum_d;
    quot_q    <= quot_d;
    rem_q     <= rem_d;
    div_cnt_q <= div_cnt_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[rtl/core/spq_checker.sv]
// Port-level checks of the sorted priority queue, bound to the top level.
module spq_checker #(
  parameter int unsigned DEPTH = 64
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input spq_pkg::spq_rsp_t out_data_i
);
  import spq_pkg::*;

  // stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result word changed while stalled");

  // one request at a time: the input closes after a word is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input still open after taking a word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.status == ST_FULL)
    |-> out_data_i.entry_count == COUNT_W'(DEPTH))
    else $error("full status without a full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.status == ST_EMPTY)
    |-> out_data_i.entry_count == '0 && out_data_i.removed_tag == '0
        && out_data_i.total_completion == '0 && out_data_i.average_completion == '0)
    else $error("empty status with nonzero fields");

endmodule

bind sorted_priority_queue_avg_time spq_checker #(
  .DEPTH(DEPTH)
) u_spq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_i (in_ready_o),
  .out_valid_i(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_i (out_data_o)
);
